>>> hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes and register map constants that the engine, its register
// block and its checker use.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	// Bus commands. The code 7 is unused and ignored by the engine.
	typedef enum logic [2:0] {
		OP_RELEASE = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_WRITE   = 3'd3,
		OP_READ    = 3'd4,
		OP_SACK    = 3'd5,
		OP_RACK    = 3'd6
	} op_t;

	// Register map: word index taken from paddr[2].
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_LONG_WAIT  = 1'b0;
	localparam logic REG_SHORT_WAIT = 1'b1;

	// Width of the writable field of each wait register.
	localparam int unsigned REG_FIELD_W = 16;

	// Reset values of the wait registers, in ticks.
	localparam logic [REG_FIELD_W-1:0] LONG_WAIT_RST  = 16'd5;
	localparam logic [REG_FIELD_W-1:0] SHORT_WAIT_RST = 16'd4;

endpackage

`default_nettype wire

>>> hw/rtl/i2cm_apb_regs.sv
// ----------------------------------------------------------------------------
// I2C master wait registers
// APB-style register block holding the long and short wait counts.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_apb_regs #(
	parameter int unsigned WAIT_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [i2cm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [WAIT_BITS-1:0]          long_wait,
	output logic      [WAIT_BITS-1:0]          short_wait
);

	logic                 wr_en;
	logic [31:0]          wdata_field;
	logic [31:0]          lw_rst_ext;
	logic [31:0]          sw_rst_ext;
	logic [WAIT_BITS-1:0] long_wait_q;
	logic [WAIT_BITS-1:0] short_wait_q;

	// Only the low 16 bits are writable; narrower counters keep fewer bits.
	assign wdata_field = {16'd0, pwdata[i2cm_pkg::REG_FIELD_W-1:0]};
	assign lw_rst_ext  = {16'd0, i2cm_pkg::LONG_WAIT_RST};
	assign sw_rst_ext  = {16'd0, i2cm_pkg::SHORT_WAIT_RST};

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes land at the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_wait_q  <= lw_rst_ext[WAIT_BITS-1:0];
			short_wait_q <= sw_rst_ext[WAIT_BITS-1:0];
		end else if (wr_en) begin
			if (paddr[2] == i2cm_pkg::REG_LONG_WAIT) begin
				long_wait_q <= wdata_field[WAIT_BITS-1:0];
			end else begin
				short_wait_q <= wdata_field[WAIT_BITS-1:0];
			end
		end
	end

	// Read back the addressed register, zero extended.
	always_comb begin
		if (paddr[2] == i2cm_pkg::REG_LONG_WAIT) begin
			prdata = 32'(long_wait_q);
		end else begin
			prdata = 32'(short_wait_q);
		end
	end

	assign long_wait  = long_wait_q;
	assign short_wait = short_wait_q;

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// The result word of an accepted tick is registered and shown in the cycle after it.
// Throughput: one tick word per cycle while the result side does not stall; the
// next-state logic is a single pass from the state registers, which also hold the result word.
// Reset: SCL and SDA released, engine idle, wait registers at 5 and 4.
// Each tick drives SCL and SDA (1 = released), times bus segments from the
// wait registers, shifts read data in MSB first and pulses done on the tick
// a command finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine #(
	parameter int unsigned WAIT_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// Tick input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        cmd_valid,
	input  wire logic [2:0]                  op,
	input  wire logic [7:0]                  tx_byte,
	input  wire logic                        ack_level,
	input  wire logic                        sda_in,
	// Result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             scl_out,
	output logic                             sda_out,
	output logic                             busy_res,
	output logic                             done_res,
	output logic      [7:0]                  rx_byte,
	output logic                             rx_ack
);

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_LOW       = 3'd1,
		PH_HIGH      = 3'd2,
		PH_STOP_LOW  = 3'd3,
		PH_STOP_SCL  = 3'd4,
		PH_STOP_HOLD = 3'd5,
		PH_START_REL = 3'd6,
		PH_START_SDA = 3'd7
	} phase_t;

	logic [WAIT_BITS-1:0] long_wait;
	logic [WAIT_BITS-1:0] short_wait;

	// Engine state; it is also the result word shown on the output.
	phase_t               phase_q, phase_d;
	i2cm_pkg::op_t        active_op_q, active_op_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic [3:0]           bit_cnt_q, bit_cnt_d;
	logic [WAIT_BITS-1:0] wait_cnt_q, wait_cnt_d;
	logic [7:0]           shift_q, shift_d;
	logic                 ack_q, ack_d;
	logic [7:0]           tx_hold_q, tx_hold_d;
	logic                 done_q, done_d;
	logic                 out_valid_q;

	logic                 accept;
	logic                 enter_low;
	logic [3:0]           bit_dec;
	logic [2:0]           bit_idx;

	i2cm_apb_regs #(
		.WAIT_BITS (WAIT_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.long_wait  (long_wait),
		.short_wait (short_wait)
	);

	// A zero wait count behaves as a single tick.
	function automatic logic [WAIT_BITS-1:0] load_wait(input logic [WAIT_BITS-1:0] w);
		if (w == '0) begin
			return '0;
		end
		return w - 1'b1;
	endfunction

	// The result word is the state itself, so a new tick is taken as soon
	// as the current word is gone or leaves in this cycle.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign bit_dec = (bit_cnt_q == 4'd0) ? 4'd0 : bit_cnt_q - 4'd1;

	// Next-state logic for one tick.
	always_comb begin
		phase_d     = phase_q;
		active_op_d = active_op_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		bit_cnt_d   = bit_cnt_q;
		wait_cnt_d  = wait_cnt_q;
		shift_d     = shift_q;
		ack_d       = ack_q;
		tx_hold_d   = tx_hold_q;
		done_d      = 1'b0;
		enter_low   = 1'b0;

		if (phase_q == PH_IDLE) begin
			// Idle: take a new command if one with a used code is offered.
			if (cmd_valid && op <= 3'(i2cm_pkg::OP_RACK)) begin
				active_op_d = i2cm_pkg::op_t'(op);
				case (i2cm_pkg::op_t'(op))
					i2cm_pkg::OP_RELEASE: begin
						scl_d  = 1'b1;
						sda_d  = 1'b1;
						done_d = 1'b1;
					end
					i2cm_pkg::OP_START: begin
						scl_d      = 1'b1;
						sda_d      = 1'b1;
						wait_cnt_d = load_wait(long_wait);
						phase_d    = PH_START_REL;
					end
					i2cm_pkg::OP_STOP: begin
						scl_d      = 1'b0;
						sda_d      = 1'b0;
						wait_cnt_d = load_wait(short_wait);
						phase_d    = PH_STOP_LOW;
					end
					i2cm_pkg::OP_WRITE: begin
						tx_hold_d = tx_byte;
						bit_cnt_d = 4'd8;
						enter_low = 1'b1;
					end
					i2cm_pkg::OP_READ: begin
						bit_cnt_d = 4'd8;
						enter_low = 1'b1;
					end
					i2cm_pkg::OP_SACK: begin
						tx_hold_d = {7'd0, ack_level};
						bit_cnt_d = 4'd1;
						enter_low = 1'b1;
					end
					default: begin
						bit_cnt_d = 4'd1;
						enter_low = 1'b1;
					end
				endcase
			end
		end else if (wait_cnt_q != '0) begin
			// Segment still running.
			wait_cnt_d = wait_cnt_q - 1'b1;
		end else begin
			// Segment ends: move to the next one.
			case (phase_q)
				PH_LOW: begin
					scl_d      = 1'b1;
					wait_cnt_d = load_wait(short_wait);
					phase_d    = PH_HIGH;
				end
				PH_HIGH: begin
					if (active_op_q == i2cm_pkg::OP_READ) begin
						shift_d = {shift_q[6:0], sda_in};
					end else if (active_op_q == i2cm_pkg::OP_RACK) begin
						ack_d = sda_in;
					end
					bit_cnt_d = bit_dec;
					if (bit_dec != 4'd0) begin
						enter_low = 1'b1;
					end else begin
						scl_d = 1'b0;
						if (active_op_q == i2cm_pkg::OP_READ ||
						    active_op_q == i2cm_pkg::OP_RACK) begin
							sda_d = 1'b1;
						end
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
				end
				PH_STOP_LOW: begin
					scl_d      = 1'b1;
					wait_cnt_d = load_wait(short_wait);
					phase_d    = PH_STOP_SCL;
				end
				PH_STOP_SCL: begin
					sda_d      = 1'b1;
					wait_cnt_d = load_wait(long_wait);
					phase_d    = PH_STOP_HOLD;
				end
				PH_STOP_HOLD: begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_START_REL: begin
					sda_d      = 1'b0;
					wait_cnt_d = load_wait(short_wait);
					phase_d    = PH_START_SDA;
				end
				PH_START_SDA: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		// Bit position of the data bit to drive, wrapping as a 3-bit value.
		bit_idx = bit_cnt_d[2:0] - 3'd1;

		// Start of a bit: SCL low, data bit or released SDA, long setup.
		if (enter_low) begin
			scl_d = 1'b0;
			if (active_op_d == i2cm_pkg::OP_WRITE || active_op_d == i2cm_pkg::OP_SACK) begin
				sda_d = tx_hold_d[bit_idx];
			end else begin
				sda_d = 1'b1;
			end
			wait_cnt_d = load_wait(long_wait);
			phase_d    = PH_LOW;
		end
	end

	// State and result registers advance on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			active_op_q <= i2cm_pkg::OP_RELEASE;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			bit_cnt_q   <= 4'd0;
			wait_cnt_q  <= '0;
			shift_q     <= 8'd0;
			ack_q       <= 1'b0;
			tx_hold_q   <= 8'd0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				active_op_q <= active_op_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				bit_cnt_q   <= bit_cnt_d;
				wait_cnt_q  <= wait_cnt_d;
				shift_q     <= shift_d;
				ack_q       <= ack_d;
				tx_hold_q   <= tx_hold_d;
				done_q      <= done_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = scl_q;
	assign sda_out   = sda_q;
	assign busy_res  = (phase_q != PH_IDLE);
	assign done_res  = done_q;
	assign rx_byte   = shift_q;
	assign rx_ack    = ack_q;

endmodule

`default_nettype wire

>>> hw/rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        cmd_valid,
	input wire logic [2:0]                  op,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        scl_out,
	input wire logic                        sda_out,
	input wire logic                        busy_res,
	input wire logic                        done_res,
	input wire logic [7:0]                  rx_byte,
	input wire logic                        rx_ack
);

	// A finished command leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// The input side only stalls behind a waiting result word.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// A release taken while idle frees both lines and finishes at once.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !busy_res && cmd_valid && op == i2cm_pkg::OP_RELEASE
		|=> out_valid && done_res && scl_out && sda_out && !busy_res)
		else $error("release command did not complete in one tick");

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall
		|=> out_valid && $stable({scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack}))
		else $error("result word changed while stalled");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.cmd_valid (cmd_valid),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.scl_out   (scl_out),
	.sda_out   (sda_out),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.rx_byte   (rx_byte),
	.rx_ack    (rx_ack)
);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the I2C master bit engine
// Feeds timing ticks, with and without bus commands, through the tick channel.
// A built-in bus predictor follows every accepted tick and queues the expected
// result word. Each returned word is checked field by field. The wait
// registers are set over the APB port between phases, and both channel sides
// idle at random in some phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	// Unused command code; the engine must ignore it.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// How the SDA level is chosen for the ticks that follow a command.
	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_RANDOM = 2;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       ack_level;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       rx_ack;
	} bus_word_t;

	// Bus segments of the predictor.
	typedef enum logic [2:0] {
		SEG_IDLE,
		SEG_LOW,
		SEG_HIGH,
		SEG_STOP_LOW,
		SEG_STOP_SCL,
		SEG_STOP_HOLD,
		SEG_START_REL,
		SEG_START_SDA
	} seg_t;

	// Clock, reset and block ports.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [i2cm_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        cmd_valid = 1'b0;
	logic [2:0]  op        = 3'd0;
	logic [7:0]  tx_byte   = 8'd0;
	logic        ack_level = 1'b0;
	logic        sda_in    = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        rx_ack;

	// Stimulus and checking state.
	tick_t     tick_q[$];
	bus_word_t bus_word_q[$];
	int        err_cnt        = 0;
	int        ticks_queued   = 0;
	bit        send_gaps_on   = 1'b0;
	bit        recv_stalls_on = 1'b0;
	bit        tick_taken     = 1'b0;
	bit        word_seen      = 1'b0;
	int        send_gap       = 0;
	int        recv_hold      = 0;

	// Predictor copy of the wait registers and the bus state.
	logic [15:0]   cfg_long   = i2cm_pkg::LONG_WAIT_RST;
	logic [15:0]   cfg_short  = i2cm_pkg::SHORT_WAIT_RST;
	logic          bus_scl    = 1'b1;
	logic          bus_sda    = 1'b1;
	i2cm_pkg::op_t bus_op     = i2cm_pkg::OP_RELEASE;
	seg_t          bus_seg    = SEG_IDLE;
	logic [3:0]    bits_left  = 4'd0;
	logic [15:0]   wait_left  = 16'd0;
	logic [7:0]    rx_shift   = 8'd0;
	logic          rx_ack_bit = 1'b0;
	logic [7:0]    tx_hold    = 8'd0;

	i2c_master_bit_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd_valid (cmd_valid),
		.op        (op),
		.tx_byte   (tx_byte),
		.ack_level (ack_level),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl_out   (scl_out),
		.sda_out   (sda_out),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rx_byte   (rx_byte),
		.rx_ack    (rx_ack)
	);

	always #5 clk = ~clk;

	// A wait of zero counts as one tick.
	function automatic logic [15:0] reload(input logic [15:0] w);
		return (w == 16'd0) ? 16'd0 : w - 16'd1;
	endfunction

	// SCL low with the next data bit on SDA, or SDA released for reads.
	function automatic void enter_low();
		bus_scl = 1'b0;
		if (bus_op == i2cm_pkg::OP_WRITE || bus_op == i2cm_pkg::OP_SACK) begin
			bus_sda = tx_hold[(bits_left - 4'd1) & 4'd7];
		end else begin
			bus_sda = 1'b1;
		end
		wait_left = reload(cfg_long);
		bus_seg   = SEG_LOW;
	endfunction

	// Advances the bus predictor by one tick and returns the expected word.
	function automatic bus_word_t step_bus(input tick_t t);
		bus_word_t w;
		logic      fin;
		fin = 1'b0;
		if (bus_seg == SEG_IDLE) begin
			if (t.cmd_valid && t.op != OP_UNUSED) begin
				bus_op = i2cm_pkg::op_t'(t.op);
				case (bus_op)
					i2cm_pkg::OP_RELEASE: begin
						bus_scl = 1'b1;
						bus_sda = 1'b1;
						fin     = 1'b1;
					end
					i2cm_pkg::OP_START: begin
						bus_scl   = 1'b1;
						bus_sda   = 1'b1;
						wait_left = reload(cfg_long);
						bus_seg   = SEG_START_REL;
					end
					i2cm_pkg::OP_STOP: begin
						bus_scl   = 1'b0;
						bus_sda   = 1'b0;
						wait_left = reload(cfg_short);
						bus_seg   = SEG_STOP_LOW;
					end
					i2cm_pkg::OP_WRITE: begin
						tx_hold   = t.tx_byte;
						bits_left = 4'd8;
						enter_low();
					end
					i2cm_pkg::OP_READ: begin
						bits_left = 4'd8;
						enter_low();
					end
					i2cm_pkg::OP_SACK: begin
						tx_hold   = {7'd0, t.ack_level};
						bits_left = 4'd1;
						enter_low();
					end
					default: begin
						bits_left = 4'd1;
						enter_low();
					end
				endcase
			end
		end else if (wait_left != 16'd0) begin
			wait_left = wait_left - 16'd1;
		end else begin
			case (bus_seg)
				SEG_LOW: begin
					bus_scl   = 1'b1;
					wait_left = reload(cfg_short);
					bus_seg   = SEG_HIGH;
				end
				SEG_HIGH: begin
					// SDA is sampled as the high segment ends.
					if (bus_op == i2cm_pkg::OP_READ) begin
						rx_shift = {rx_shift[6:0], t.sda_in};
					end else if (bus_op == i2cm_pkg::OP_RACK) begin
						rx_ack_bit = t.sda_in;
					end
					if (bits_left != 4'd0) begin
						bits_left = bits_left - 4'd1;
					end
					if (bits_left != 4'd0) begin
						enter_low();
					end else begin
						bus_scl = 1'b0;
						if (bus_op == i2cm_pkg::OP_READ || bus_op == i2cm_pkg::OP_RACK) begin
							bus_sda = 1'b1;
						end
						bus_seg = SEG_IDLE;
						fin     = 1'b1;
					end
				end
				SEG_STOP_LOW: begin
					bus_scl   = 1'b1;
					wait_left = reload(cfg_short);
					bus_seg   = SEG_STOP_SCL;
				end
				SEG_STOP_SCL: begin
					bus_sda   = 1'b1;
					wait_left = reload(cfg_long);
					bus_seg   = SEG_STOP_HOLD;
				end
				SEG_STOP_HOLD: begin
					bus_seg = SEG_IDLE;
					fin     = 1'b1;
				end
				SEG_START_REL: begin
					bus_sda   = 1'b0;
					wait_left = reload(cfg_short);
					bus_seg   = SEG_START_SDA;
				end
				default: begin
					bus_scl = 1'b0;
					bus_seg = SEG_IDLE;
					fin     = 1'b1;
				end
			endcase
		end
		w.scl     = bus_scl;
		w.sda     = bus_sda;
		w.busy    = (bus_seg != SEG_IDLE);
		w.done    = fin;
		w.rx_byte = rx_shift;
		w.rx_ack  = rx_ack_bit;
		return w;
	endfunction

	// Ticks a command keeps the engine busy after the tick that starts it.
	function automatic int busy_span(input logic [2:0] code);
		int lw;
		int sw;
		lw = (cfg_long == 16'd0) ? 1 : int'(cfg_long);
		sw = (cfg_short == 16'd0) ? 1 : int'(cfg_short);
		case (code)
			i2cm_pkg::OP_START: return lw + sw;
			i2cm_pkg::OP_STOP: return 2 * sw + lw;
			i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ: return 8 * (lw + sw);
			i2cm_pkg::OP_SACK, i2cm_pkg::OP_RACK: return lw + sw;
			default: return 0;
		endcase
	endfunction

	// A tick with no command unless noise is asked for.
	function automatic tick_t quiet_tick(input int sda_mode, input bit noisy);
		tick_t t;
		t.cmd_valid = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
		t.op        = 3'($urandom_range(0, 7));
		t.tx_byte   = 8'($urandom_range(0, 255));
		t.ack_level = 1'($urandom_range(0, 1));
		case (sda_mode)
			SDA_LOW: t.sda_in = 1'b0;
			SDA_HIGH: t.sda_in = 1'b1;
			default: t.sda_in = 1'($urandom_range(0, 1));
		endcase
		return t;
	endfunction

	// Queues one command and the ticks it needs to finish.
	task automatic issue(input logic [2:0] code, input logic [7:0] txb, input logic ackl,
			input int sda_mode, input bit noisy);
		tick_t t;
		int    span;
		span = busy_span(code);
		t = quiet_tick(sda_mode, 1'b0);
		t.cmd_valid = 1'b1;
		t.op        = code;
		t.tx_byte   = txb;
		t.ack_level = ackl;
		tick_q.push_back(t);
		repeat (span) tick_q.push_back(quiet_tick(sda_mode, noisy));
		ticks_queued += span + 1;
	endtask

	// Writes a wait register over APB and reads it back.
	task automatic write_wait_reg(input logic reg_sel, input logic [15:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== value) begin
			err_cnt++;
			$display("%0t ns: register %0d read back, expected %0h, actual %0h",
				$time, reg_sel, value, prdata[15:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == i2cm_pkg::REG_LONG_WAIT) begin
			cfg_long = value;
		end else begin
			cfg_short = value;
		end
	endtask

	task automatic set_waits(input logic [15:0] lw, input logic [15:0] sw);
		write_wait_reg(i2cm_pkg::REG_LONG_WAIT, lw);
		write_wait_reg(i2cm_pkg::REG_SHORT_WAIT, sw);
	endtask

	// Waits until every queued tick is taken and every word has come back.
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (tick_q.size() != 0 || in_valid || bus_word_q.size() != 0);
	endtask

	// Runs quiet ticks until the engine is idle again.
	task automatic settle();
		wait_drained();
		while (bus_seg != SEG_IDLE) begin
			repeat (256) tick_q.push_back(quiet_tick(SDA_RANDOM, 1'b0));
			wait_drained();
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
		end
	endtask

	// Tick driver: presents the next queued word, after a random gap when gaps are on.
	always @(negedge clk) begin : tick_driver
		tick_t t;
		logic  drive_valid;
		drive_valid = in_valid && !tick_taken;
		if (arst_n && !drive_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (tick_q.size() > 0) begin
				t = tick_q.pop_front();
				cmd_valid   <= t.cmd_valid;
				op          <= t.op;
				tx_byte     <= t.tx_byte;
				ack_level   <= t.ack_level;
				sda_in      <= t.sda_in;
				drive_valid = 1'b1;
				send_gap    = send_gaps_on ? $urandom_range(0, 15) : 0;
			end
		end
		in_valid <= drive_valid;
	end

	// Result receiver: holds out_stall at random after each word when stalls are on.
	always @(negedge clk) begin : word_receiver
		if (word_seen) begin
			recv_hold = recv_stalls_on ? $urandom_range(0, 15) : 0;
		end
		if (recv_hold > 0) begin
			recv_hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predicts each accepted tick and checks each returned word.
	always @(posedge clk) begin : bus_monitor
		bus_word_t want;
		bus_word_t got;
		tick_taken = 1'b0;
		word_seen  = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tick_taken = 1'b1;
				bus_word_q.push_back(step_bus({cmd_valid, op, tx_byte, ack_level, sda_in}));
			end
			if (out_valid && !out_stall) begin
				word_seen = 1'b1;
				got = {scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack};
				if (bus_word_q.size() == 0) begin
					err_cnt++;
					$display("%0t ns: unexpected result word, expected none, actual %0h",
						$time, got);
				end else begin
					want = bus_word_q.pop_front();
					check_field("scl_out", 8'(want.scl), 8'(got.scl));
					check_field("sda_out", 8'(want.sda), 8'(got.sda));
					check_field("busy_res", 8'(want.busy), 8'(got.busy));
					check_field("done_res", 8'(want.done), 8'(got.done));
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("rx_ack", 8'(want.rx_ack), 8'(got.rx_ack));
				end
			end
		end
	end

	// Stimulus: directed commands, then random transactions in chunks.
	initial begin : stimulus
		int budget;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset timing, with idling on both sides.
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		set_waits(16'd5, 16'd4);
		issue(i2cm_pkg::OP_RELEASE, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_START, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_RACK, 8'h00, 1'b1, SDA_LOW, 1'b0);
		issue(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_RACK, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
		issue(i2cm_pkg::OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		issue(i2cm_pkg::OP_SACK, 8'hFF, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_READ, 8'hFF, 1'b1, SDA_LOW, 1'b0);
		issue(i2cm_pkg::OP_SACK, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		// Commands offered while busy must be ignored.
		issue(i2cm_pkg::OP_READ, 8'h3C, 1'b0, SDA_RANDOM, 1'b1);
		// The unused code leaves the idle engine alone.
		issue(OP_UNUSED, 8'hC3, 1'b1, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		settle();

		// Shortest waits.
		set_waits(16'd1, 16'd1);
		issue(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_RACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_READ, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_SACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_RELEASE, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		settle();

		// A wait register of zero behaves as a single tick.
		set_waits(16'd0, 16'd0);
		issue(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_SACK, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		issue(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		settle();

		// Long waits, one ack bit, no idling.
		send_gaps_on   = 1'b0;
		recv_stalls_on = 1'b0;
		set_waits(16'd24, 16'd16);
		issue(i2cm_pkg::OP_RACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		settle();

		// Random part: mostly well-formed transactions, some stray commands.
		ticks_queued = 0;
		for (int chunk = 0; chunk < 4; chunk++) begin
			send_gaps_on   = chunk[0];
			recv_stalls_on = chunk[1];
			if (chunk == 0) begin
				set_waits(16'd1, 16'd1);
			end else begin
				set_waits(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
			end
			budget = ticks_queued + 20;
			while (ticks_queued < budget) begin
				if ($urandom_range(0, 9) < 7) begin
					issue(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM,
						$urandom_range(0, 3) == 0);
					issue(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM,
						$urandom_range(0, 3) == 0);
					issue(i2cm_pkg::OP_RACK, 8'($urandom), 1'($urandom), SDA_RANDOM, 1'b0);
					repeat ($urandom_range(0, 2)) begin
						if ($urandom_range(0, 1)) begin
							issue(i2cm_pkg::OP_READ, 8'($urandom), 1'($urandom),
								SDA_RANDOM, $urandom_range(0, 3) == 0);
							issue(i2cm_pkg::OP_SACK, 8'($urandom), 1'($urandom),
								SDA_RANDOM, 1'b0);
						end else begin
							issue(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom),
								SDA_RANDOM, $urandom_range(0, 3) == 0);
							issue(i2cm_pkg::OP_RACK, 8'($urandom), 1'($urandom),
								SDA_RANDOM, 1'b0);
						end
					end
					issue(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM,
						$urandom_range(0, 3) == 0);
				end else begin
					issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						SDA_RANDOM, 1'($urandom_range(0, 1)));
				end
				// Short random tail, now and then with a stray command in it.
				repeat ($urandom_range(0, 3)) begin
					tick_q.push_back(quiet_tick(SDA_RANDOM, $urandom_range(0, 7) == 0));
					ticks_queued++;
				end
			end
			settle();
		end

		// Let any stray word show up before the verdict.
		repeat (4) @(posedge clk);
		if (err_cnt == 0 && bus_word_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin : run_limit
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

>>> i2c_master_bit_engine.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_apb_regs.sv
hw/rtl/i2c_master_bit_engine.sv
hw/rtl/i2cm_checker.sv
sim/tb_top.sv
